// File: hdl/fresnel_cosine_rational_approx_top_defines.svh
// Assertion helpers for the Fresnel cosine block.
`ifndef FRESNEL_COSINE_RATIONAL_APPROX_TOP_DEFINES_SVH
`define FRESNEL_COSINE_RATIONAL_APPROX_TOP_DEFINES_SVH

// Property that must hold on every edge outside reset.
`define FCRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold on every edge, reset included.
`define FCRA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/fcra_pkg.sv
package fcra_pkg;
   localparam int XW = 32;
   localparam int AW = 48;
   localparam int CW = 32;
   localparam int NUM_DEG = 10;
   localparam int DEN_DEG = 8;
   localparam int DIV_BITS = 32;
   localparam logic signed [AW-1:0] SAT_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_MIN = {1'b1, {(AW-1){1'b0}}};

   typedef logic signed [AW-1:0] acc_type;

   function automatic acc_type num_coef(input int k);
      case (k)
         0: num_coef = 48'sd4294967296;
         1: num_coef = -48'sd622694380;
         2: num_coef = -48'sd860936348;
         3: num_coef = 48'sd130529559;
         4: num_coef = 48'sd75991654;
         5: num_coef = -48'sd12199519;
         6: num_coef = -48'sd2234534;
         7: num_coef = 48'sd432550;
         8: num_coef = 48'sd16084;
         9: num_coef = -48'sd5977;
         10: num_coef = 48'sd271;
         default: num_coef = '0;
      endcase
   endfunction

   function automatic acc_type den_coef(input int k);
      case (k)
         0: den_coef = 48'sd4294967296;
         1: den_coef = -48'sd622694380;
         2: den_coef = 48'sd198804355;
         3: den_coef = -48'sd23114120;
         4: den_coef = 48'sd3988858;
         5: den_coef = -48'sd351745;
         6: den_coef = 48'sd39195;
         7: den_coef = -48'sd2104;
         8: den_coef = 48'sd132;
         default: den_coef = '0;
      endcase
   endfunction
endpackage

// File: hdl/fcra_stream_if.sv
interface fcra_stream_if #(parameter int W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fcra_horner_step.sv
// One Horner step: sat48(coef + round(h * z / 2^24)). Holds the first of the
// step's two register stages; the caller registers h_out as the second.
module fcra_horner_step
   import fcra_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  acc_type       h_in,
   input  logic [30:0]   z_in,
   input  acc_type       coef,
   output acc_type       h_out,
   output logic          ovf_out
);
   logic          neg_ff;
   logic [55:0]   plo_ff;
   logic [55:0]   phi_ff;
   logic [47:0]   mag;
   logic [55:0]   r;
   logic signed [57:0] rs;
   logic signed [57:0] s;

   assign mag = h_in[AW-1] ? 48'(-h_in) : 48'(h_in);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= h_in[AW-1];
         plo_ff <= 56'(mag[23:0]) * 56'(z_in);
         phi_ff <= 56'(mag[47:24]) * 56'(z_in);
      end
   end

   always_comb begin
      // upper partial product already carries the 2^24 scale; only the lower one rounds
      r = 56'(phi_ff) + 56'((plo_ff + 56'(1 << 23)) >> 24);
      rs = signed'({2'b00, r});
      s = 58'(coef) + (neg_ff ? -rs : rs);
      if (s > 58'(SAT_MAX)) begin
         h_out = SAT_MAX; ovf_out = 1'b1;
      end else if (s < 58'(SAT_MIN)) begin
         h_out = SAT_MIN; ovf_out = 1'b1;
      end else begin
         h_out = AW'(s); ovf_out = 1'b0;
      end
   end
endmodule

// File: hdl/fresnel_cosine_rational_approx_top.sv
// Fresnel cosine integral C(x) for a Q4.28 argument as x*P(x^2)/Q(x^2),
// result Q2.30 with a saturation flag. Fully pipelined: one transaction in
// and one out per clock while the output is not stalled. The stages are the
// magnitude and square registers, the Horner steps (ten steps for P, Q runs
// alongside in the last eight), the x*P stages, one divider setup stage, 32
// restoring divider stages that each retire one quotient bit, and the output
// register. The pipeline advances whenever the output register is empty or
// being taken, so a stall freezes every stage.
`include "fresnel_cosine_rational_approx_top_defines.svh"
module fresnel_cosine_rational_approx_top
   import fcra_pkg::*;
(
   input  logic clock,
   input  logic reset,
   fcra_stream_if.sink   req,
   fcra_stream_if.source rsp
);
   localparam int HS = NUM_DEG;           // Horner steps (P longer than Q)
   localparam int NS = 2 + 2 * HS + 2 + 1 + DIV_BITS + 1;

   logic adv;
   logic stall;
   logic [NS-1:0] vld_ff;
   assign adv = !rsp.valid || rsp.ready;
   assign stall = rsp.valid && !rsp.ready;
   assign req.ready = adv;

   // stages 0 and 1: magnitude, then square
   logic          xneg0_ff;
   logic [31:0]   xm0_ff;
   logic [63:0]   sq1_ff;
   logic          xneg1_ff;
   logic [31:0]   xm1_ff;
   logic [31:0]   xm_in;
   assign xm_in = req.data[31] ? 32'(-req.data) : req.data;

   always_ff @(posedge clock) begin
      if (adv) begin
         xneg0_ff <= req.data[31];
         xm0_ff <= xm_in;
         sq1_ff <= 64'(xm0_ff) * 64'(xm0_ff);
         xneg1_ff <= xneg0_ff;
         xm1_ff <= xm0_ff;
      end
   end

   logic [30:0] z1;
   assign z1 = 31'((sq1_ff + 64'h8000_0000) >> 32);

   // Horner chain; Q runs alongside P using steps HS-DEN_DEG onward
   acc_type hp [HS+1];
   acc_type hq [HS+1];
   logic    fl [HS+1];
   logic [30:0] zz [HS+1];
   logic [31:0] xx [HS+1];
   logic        xn [HS+1];
   assign hp[0] = num_coef(NUM_DEG);
   assign hq[0] = den_coef(DEN_DEG);
   assign fl[0] = 1'b0;
   assign zz[0] = z1;
   assign xx[0] = xm1_ff;
   assign xn[0] = xneg1_ff;

   for (genvar k = 0; k < HS; k++) begin : g_h
      acc_type po, qo;
      logic pv, qv;
      logic [30:0] z_a_ff, z_b_ff;
      logic [31:0] x_a_ff, x_b_ff;
      logic n_a_ff, n_b_ff, f_a_ff, f_b_ff;
      acc_type q_b_ff, p_b_ff;
      fcra_horner_step u_p (.clock, .en(adv), .h_in(hp[k]), .z_in(zz[k]),
         .coef(num_coef(NUM_DEG - 1 - k)), .h_out(po), .ovf_out(pv));
      if (k >= HS - DEN_DEG) begin : g_q
         fcra_horner_step u_q (.clock, .en(adv), .h_in(hq[k]), .z_in(zz[k]),
            .coef(den_coef(HS - 1 - k)), .h_out(qo), .ovf_out(qv));
      end else begin : g_nq
         acc_type q_a_ff;
         always_ff @(posedge clock) begin
            if (adv) q_a_ff <= hq[k];
         end
         assign qo = q_a_ff;
         assign qv = 1'b0;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            z_a_ff <= zz[k]; x_a_ff <= xx[k]; n_a_ff <= xn[k]; f_a_ff <= fl[k];
            z_b_ff <= z_a_ff; x_b_ff <= x_a_ff; n_b_ff <= n_a_ff;
            f_b_ff <= f_a_ff || pv || qv;
            p_b_ff <= po; q_b_ff <= qo;
         end
      end
      assign hp[k+1] = p_b_ff;
      assign hq[k+1] = q_b_ff;
      assign zz[k+1] = z_b_ff;
      assign xx[k+1] = x_b_ff;
      assign xn[k+1] = n_b_ff;
      assign fl[k+1] = f_b_ff;
   end

   // t = round(|num| * xm / 2^28), two stages; product split in two halves
   logic          tneg_a_ff, xn_a_ff, fl_a_ff;
   logic [55:0]   tpl_ff, tph_ff;
   acc_type       den_a_ff, den_b_ff;
   logic [47:0]   nmag;
   logic [47:0]   tm_b_ff;
   logic          tneg_b_ff, fl_b_ff;
   logic [79:0]   tp;
   logic [52:0]   tr;
   logic [52:0]   tlim;
   logic [47:0]   tmag;
   logic          tovf;
   assign nmag = hp[HS][AW-1] ? 48'(-hp[HS]) : 48'(hp[HS]);
   always_comb begin
      tp = (80'(tph_ff) << 24) + 80'(tpl_ff);
      tr = 53'((tp + 80'(1 << 27)) >> 28);
      // a negative product may reach -2^47 before it clamps
      tlim = 53'({1'b0, SAT_MAX}) + 53'(tneg_a_ff);
      tovf = tr > tlim;
      tmag = tovf ? 48'(tlim) : 48'(tr);
   end
   // t is kept as sign and magnitude: after the sign of x it may reach +2^47
   always_ff @(posedge clock) begin
      if (adv) begin
         tneg_a_ff <= hp[HS][AW-1];
         xn_a_ff <= xn[HS];
         fl_a_ff <= fl[HS];
         tpl_ff <= 56'(nmag[23:0]) * 56'(xx[HS]);
         tph_ff <= 56'(nmag[47:24]) * 56'(xx[HS]);
         den_a_ff <= hq[HS];
         tm_b_ff <= tmag;
         tneg_b_ff <= tneg_a_ff ^ xn_a_ff;
         fl_b_ff <= fl_a_ff || tovf;
         den_b_ff <= den_a_ff;
      end
   end

   // divider: setup stage then DIV_BITS restoring steps
   localparam int RW = 50;
   typedef struct packed {
      logic          dz;
      logic          big;
      logic          neg;
      logic          tpos;
      logic          tnz;
      logic          fl;
      logic [47:0]   dm;
      logic [RW-1:0] rem;
      logic [31:0]   q;
   } div_type;

   div_type d [DIV_BITS+1];
   logic [47:0] dm0;
   logic        tnz0;
   assign dm0 = den_b_ff[AW-1] ? 48'(-den_b_ff) : 48'(den_b_ff);
   assign tnz0 = tm_b_ff != '0;
   div_type d0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff.dz <= den_b_ff == '0;
         d0_ff.big <= {1'b0, tm_b_ff} >= {dm0, 1'b0};
         d0_ff.neg <= (tneg_b_ff && tnz0) != den_b_ff[AW-1];
         d0_ff.tpos <= !tneg_b_ff && tnz0;
         d0_ff.tnz <= tnz0;
         d0_ff.fl <= fl_b_ff;
         d0_ff.dm <= dm0;
         d0_ff.rem <= RW'(tm_b_ff);
         d0_ff.q <= '0;
      end
   end
   assign d[0] = d0_ff;
   // first step yields integer bit (tm<2dm), then 30 fraction bits, then one rounding bit
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_d
      div_type step_in, r_ff;
      always_comb begin
         step_in = d[i];
         if (i == 0) begin
            if (d[i].rem >= RW'(d[i].dm)) begin
               step_in.rem = d[i].rem - RW'(d[i].dm); step_in.q = 32'd1;
            end
         end else begin
            step_in.q = {d[i].q[30:0], 1'b0};
            if ({d[i].rem[RW-2:0], 1'b0} >= RW'(d[i].dm)) begin
               step_in.rem = {d[i].rem[RW-2:0], 1'b0} - RW'(d[i].dm);
               step_in.q[0] = 1'b1;
            end else step_in.rem = {d[i].rem[RW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) r_ff <= step_in;
      end
      assign d[i+1] = r_ff;
   end

   // q holds 31 quotient bits plus one round bit in the lsb
   logic [32:0] qr;
   logic [31:0] res;
   logic        fres;
   div_type dl;
   assign dl = d[DIV_BITS];
   always_comb begin
      qr = 33'(dl.q[31:1]) + 33'(dl.q[0]);
      fres = dl.fl;
      if (dl.dz) begin
         fres = 1'b1;
         res = !dl.tnz ? 32'd0 : (dl.tpos ? 32'h7FFF_FFFF : 32'h8000_0000);
      end else if (dl.big) begin
         fres = 1'b1;
         res = dl.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (!dl.neg && qr > 33'h7FFF_FFFF) begin
         fres = 1'b1;
         res = 32'h7FFF_FFFF;
      end else begin
         res = dl.neg ? 32'(-qr) : qr[31:0];
      end
   end

   logic [CW:0] out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req.valid};
      end
      if (adv) out_ff <= {fres, res};
   end
   assign rsp.valid = vld_ff[NS-1];
   assign rsp.data = out_ff;

   `FCRA_ASSERT(a_ready_flow, clock, reset, stall |-> !req.ready, "ready high during stall")
   `FCRA_ASSERT(a_hold, clock, reset, stall |=> rsp.valid && $stable(rsp.data), "lost result")
   `FCRA_ASSERT(a_ready_empty, clock, reset, !rsp.valid |-> req.ready, "input blocked")
   `FCRA_ASSERT_ALWAYS(a_reset, clock, $past(reset) |-> !rsp.valid, "valid after reset")
endmodule
